// ===== hdl/losm_pkg.sv =====
// ----------------------------------------------------------------------------
// losm_pkg - shared definitions for the LED open/short monitor
// Status and command codes, register indexes, reset values and the
// arithmetic helpers used by the channel lanes.
// ----------------------------------------------------------------------------
package losm_pkg;

	localparam int NUM_CH = 4;

	typedef logic [15:0] duty_t;
	typedef logic [12:0] volt_t;
	typedef logic [1:0]  status_t;
	typedef logic [8:0]  count_t;
	typedef logic [10:0] adc_t;

	// Channel status codes
	localparam status_t ST_INIT   = 2'd0;
	localparam status_t ST_NORMAL = 2'd1;
	localparam status_t ST_OPEN   = 2'd2;
	localparam status_t ST_SHORT  = 2'd3;

	// Command codes
	localparam logic [1:0] MODE_SET_DUTY = 2'd0;
	localparam logic [1:0] MODE_SAMPLE   = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;
	localparam logic [1:0] MODE_SLEEP    = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_OPEN_LIMIT  = 3'd0;
	localparam logic [2:0] REG_SHORT_LIMIT = 3'd1;
	localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
	localparam logic [2:0] REG_SENSE_MIN   = 3'd3;
	localparam logic [2:0] REG_PWM_PERIOD  = 3'd4;
	localparam logic [2:0] REG_CTRL_MODE   = 3'd5;

	// Control modes that force a calibration duty
	localparam logic [2:0] CTRL_RED_ONLY   = 3'd1;
	localparam logic [2:0] CTRL_WHITE_ONLY = 3'd4;

	// Reset values
	localparam volt_t  RST_OPEN_LIMIT  = 13'd4500;
	localparam volt_t  RST_SHORT_LIMIT = 13'd500;
	localparam count_t RST_DEBOUNCE    = 9'd500;
	localparam duty_t  RST_SENSE_MIN   = 16'd480;
	localparam duty_t  RST_PWM_PERIOD  = 16'd32000;
	localparam duty_t  RST_CAL_DUTY    = 16'((32000 / 10) * 4);
	localparam volt_t  RST_VOLT_RED    = 13'd2300;
	localparam volt_t  RST_VOLT_OTHER  = 13'd2400;

	localparam int    DUTY_STEP     = 3;
	localparam int    MV_FULL_SCALE = 8000;
	localparam int    ADC_FULL      = 2047;
	localparam int    DIV10_RECIP   = 52429;  // ceil(2^19 / 10), exact for 16 bits
	localparam int    DIV10_SHIFT   = 19;

	// adc * 8000 / 2047 without a divider: 2047 = 2^11 - 1, so fold the high
	// part back onto the low part twice and finish with one compare.
	function automatic volt_t adc_to_mv(input adc_t adc);
		logic [23:0] prod;
		logic [13:0] fold1;
		logic [11:0] fold2;
		logic [12:0] quo;
		prod  = 24'(adc) * 24'(MV_FULL_SCALE);
		fold1 = 14'(prod[23:11]) + 14'(prod[10:0]);
		fold2 = 12'(fold1[13:11]) + 12'(fold1[10:0]);
		quo   = prod[23:11] + 13'(fold1[13:11]);
		if (fold2 >= 12'(ADC_FULL)) begin
			quo = quo + 13'd1;
		end
		return quo;
	endfunction

	// (period / 10) * 4 via a reciprocal multiply
	function automatic duty_t cal_duty(input duty_t period);
		logic [31:0] prod;
		prod = 32'(period) * 32'(DIV10_RECIP);
		return 16'({prod[31:DIV10_SHIFT], 2'b00});
	endfunction

	function automatic logic is_fault(input status_t st);
		return (st == ST_OPEN) || (st == ST_SHORT);
	endfunction

endpackage

// ===== hdl/led_open_short_monitor.sv =====
// ----------------------------------------------------------------------------
// led_open_short_monitor - four-channel LED open/short fault monitor
// Applies PWM duties, filters ADC readings, classifies and debounces
// open/short faults on the red, green, blue and white channels.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, mode, duty_*, adc_*   | item in
//  result   | out_valid, out_ready, status_*, volt_*,   | item out
//           | sense_mask, any_fault, first_fault_seen   |
//  config   | cfg_we, cfg_index, cfg_data               | write only
//
//  One item per cycle sustained while the result side does not stall; an
//  accepted item passes from the input register through one pass of lane
//  logic into the result register.
//  Each item updates the channel state as it leaves the input register, so
//  consecutive items see each other's effects with no bubble.
//  A stall on the result side holds the result register and then the input
//  register; in_ready drops only when both are full.
//  arst_n resets state and configuration and clears the valid flags at once.
//
module led_open_short_monitor (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] duty_red,
	input  logic [15:0] duty_green,
	input  logic [15:0] duty_blue,
	input  logic [15:0] duty_white,
	input  logic [10:0] adc_red,
	input  logic [10:0] adc_green,
	input  logic [10:0] adc_blue,
	input  logic [10:0] adc_white,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status_red,
	output logic [1:0]  status_green,
	output logic [1:0]  status_blue,
	output logic [1:0]  status_white,
	output logic [12:0] volt_red,
	output logic [12:0] volt_green,
	output logic [12:0] volt_blue,
	output logic [12:0] volt_white,
	output logic [3:0]  sense_mask,
	output logic        any_fault,
	output logic        first_fault_seen
);

	localparam int NCH = losm_pkg::NUM_CH;

	// ---------------- configuration registers ----------------
	losm_pkg::volt_t  open_limit_q;
	losm_pkg::volt_t  short_limit_q;
	losm_pkg::count_t debounce_q;
	losm_pkg::duty_t  sense_min_q;
	losm_pkg::duty_t  pwm_period_q;
	losm_pkg::duty_t  cal_duty_q;     // (period / 10) * 4, worked out on the write
	logic [2:0]       ctrl_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_limit_q  <= losm_pkg::RST_OPEN_LIMIT;
			short_limit_q <= losm_pkg::RST_SHORT_LIMIT;
			debounce_q    <= losm_pkg::RST_DEBOUNCE;
			sense_min_q   <= losm_pkg::RST_SENSE_MIN;
			pwm_period_q  <= losm_pkg::RST_PWM_PERIOD;
			cal_duty_q    <= losm_pkg::RST_CAL_DUTY;
			ctrl_mode_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				losm_pkg::REG_OPEN_LIMIT:  open_limit_q  <= cfg_data[12:0];
				losm_pkg::REG_SHORT_LIMIT: short_limit_q <= cfg_data[12:0];
				losm_pkg::REG_DEBOUNCE:    debounce_q    <= cfg_data[8:0];
				losm_pkg::REG_SENSE_MIN:   sense_min_q   <= cfg_data;
				losm_pkg::REG_PWM_PERIOD: begin
					pwm_period_q <= cfg_data;
					cal_duty_q   <= losm_pkg::cal_duty(cfg_data);
				end
				losm_pkg::REG_CTRL_MODE:   ctrl_mode_q   <= cfg_data[2:0];
				default: ;  // indexes past the list are dropped
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                 valid_s1;
	logic [1:0]           mode_s1;
	losm_pkg::duty_t      duty_s1 [NCH];
	losm_pkg::adc_t       adc_s1  [NCH];
	logic                 advance;

	// Move an item on when the result register is empty or being emptied
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1    <= mode;
			duty_s1[0] <= duty_red;
			duty_s1[1] <= duty_green;
			duty_s1[2] <= duty_blue;
			duty_s1[3] <= duty_white;
			adc_s1[0]  <= adc_red;
			adc_s1[1]  <= adc_green;
			adc_s1[2]  <= adc_blue;
			adc_s1[3]  <= adc_white;
		end
	end

	// ---------------- channel state ----------------
	losm_pkg::volt_t   volt_q     [NCH];
	losm_pkg::status_t status_q   [NCH];
	losm_pkg::count_t  count_q    [NCH];
	losm_pkg::duty_t   duty_q     [NCH];
	logic [NCH-1:0]    sense_q;
	logic              latch_q;

	losm_pkg::volt_t   volt_d     [NCH];
	losm_pkg::status_t status_d   [NCH];
	losm_pkg::count_t  count_d    [NCH];
	losm_pkg::duty_t   duty_d     [NCH];
	logic [NCH-1:0]    sense_d;
	logic              latch_d;

	// per-lane working values
	losm_pkg::duty_t   req_duty   [NCH];
	losm_pkg::duty_t   step_duty  [NCH];
	losm_pkg::duty_t   clamp_duty [NCH];
	losm_pkg::volt_t   mv         [NCH];
	losm_pkg::status_t cls        [NCH];
	logic [16:0]       duty_sum   [NCH];
	logic [14:0]       filt_sum   [NCH];
	logic              cal_active;
	logic              duty_same;
	losm_pkg::duty_t   duty_lim;
	logic [2:0]        cal_lane;

	always_comb begin
		cal_active = (ctrl_mode_q >= losm_pkg::CTRL_RED_ONLY) &&
			(ctrl_mode_q <= losm_pkg::CTRL_WHITE_ONLY);
		cal_lane   = ctrl_mode_q - losm_pkg::CTRL_RED_ONLY;
		duty_lim   = (pwm_period_q == '0) ? '0 : pwm_period_q - 16'd1;
		duty_same  = 1'b1;

		for (int i = 0; i < NCH; i++) begin
			// Duty path: pick request or calibration, add the step, saturate, clamp below the period
			if (cal_active) begin
				req_duty[i] = (cal_lane == 3'(i)) ? cal_duty_q : '0;
			end else begin
				req_duty[i] = duty_s1[i];
			end
			duty_sum[i] = 17'(req_duty[i]) + 17'(losm_pkg::DUTY_STEP);
			if (req_duty[i] == '0) begin
				step_duty[i] = '0;
			end else if (duty_sum[i][16]) begin
				step_duty[i] = '1;
			end else begin
				step_duty[i] = duty_sum[i][15:0];
			end
			if (step_duty[i] != duty_q[i]) begin
				duty_same = 1'b0;
			end
			clamp_duty[i] = (step_duty[i] >= pwm_period_q) ? duty_lim : step_duty[i];

			// Sample path: millivolts, filter, classify
			mv[i]       = losm_pkg::adc_to_mv(adc_s1[i]);
			filt_sum[i] = 15'({volt_q[i], 1'b0}) + 15'(volt_q[i]) + 15'(mv[i]);
			if (!sense_q[i]) begin
				cls[i] = status_q[i];
			end else if (mv[i] >= open_limit_q) begin
				cls[i] = losm_pkg::ST_OPEN;
			end else if (mv[i] <= short_limit_q) begin
				cls[i] = losm_pkg::ST_SHORT;
			end else begin
				cls[i] = losm_pkg::ST_NORMAL;
			end
		end

		// Default: hold everything
		latch_d = latch_q;
		sense_d = sense_q;
		for (int i = 0; i < NCH; i++) begin
			volt_d[i]   = volt_q[i];
			status_d[i] = status_q[i];
			count_d[i]  = count_q[i];
			duty_d[i]   = duty_q[i];
		end

		unique case (mode_s1)
			losm_pkg::MODE_SET_DUTY: begin
				// Unchanged duties leave the sense mask alone too
				if (!duty_same) begin
					for (int i = 0; i < NCH; i++) begin
						duty_d[i]  = clamp_duty[i];
						sense_d[i] = clamp_duty[i] > sense_min_q;
					end
				end
			end
			losm_pkg::MODE_SAMPLE: begin
				for (int i = 0; i < NCH; i++) begin
					volt_d[i] = (status_q[i] == losm_pkg::ST_NORMAL) ?
						filt_sum[i][14:2] : mv[i];
					// Debounce: a fault waits out the countdown first
					if (losm_pkg::is_fault(cls[i]) && (count_q[i] != '0)) begin
						count_d[i] = count_q[i] - 9'd1;
					end else begin
						status_d[i] = cls[i];
						count_d[i]  = debounce_q;
					end
				end
				// Sticky flag watches red, green and blue only
				for (int i = 0; i < 3; i++) begin
					if (losm_pkg::is_fault(status_d[i])) begin
						latch_d = 1'b1;
					end
				end
			end
			losm_pkg::MODE_CLEAR: begin
				for (int i = 0; i < NCH; i++) begin
					count_d[i] = debounce_q;
					if (losm_pkg::is_fault(status_q[i])) begin
						status_d[i] = losm_pkg::ST_INIT;
					end
				end
			end
			losm_pkg::MODE_SLEEP: begin
				for (int i = 0; i < NCH; i++) begin
					status_d[i] = losm_pkg::ST_INIT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				volt_q[i]   <= (i == 0) ? losm_pkg::RST_VOLT_RED : losm_pkg::RST_VOLT_OTHER;
				status_q[i] <= losm_pkg::ST_INIT;
				count_q[i]  <= losm_pkg::RST_DEBOUNCE;
				duty_q[i]   <= '0;
			end
			sense_q <= '0;
			latch_q <= 1'b0;
		end else if (advance) begin
			for (int i = 0; i < NCH; i++) begin
				volt_q[i]   <= volt_d[i];
				status_q[i] <= status_d[i];
				count_q[i]  <= count_d[i];
				duty_q[i]   <= duty_d[i];
			end
			sense_q <= sense_d;
			latch_q <= latch_d;
		end
	end

	// ---------------- result register ----------------
	losm_pkg::status_t status_s2 [NCH];
	losm_pkg::volt_t   volt_s2   [NCH];
	logic [NCH-1:0]    sense_s2;
	logic              any_s2;
	logic              latch_s2;
	logic              any_d;

	always_comb begin
		any_d = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			if (losm_pkg::is_fault(status_d[i])) begin
				any_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NCH; i++) begin
				status_s2[i] <= status_d[i];
				volt_s2[i]   <= volt_d[i];
			end
			sense_s2 <= sense_d;
			any_s2   <= any_d;
			latch_s2 <= latch_d;
		end
	end

	assign status_red       = status_s2[0];
	assign status_green     = status_s2[1];
	assign status_blue      = status_s2[2];
	assign status_white     = status_s2[3];
	assign volt_red         = volt_s2[0];
	assign volt_green       = volt_s2[1];
	assign volt_blue        = volt_s2[2];
	assign volt_white       = volt_s2[3];
	assign sense_mask       = sense_s2;
	assign any_fault        = any_s2;
	assign first_fault_seen = latch_s2;

endmodule
